[rtl/core/tkl_pkg.sv]
`timescale 1ns / 1ps
package tkl_pkg;

  localparam int ENTRIES = 10;
  localparam int PLACE_W = 4;
  localparam int KEY_W   = 16;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_READ   = 1'b1;

  typedef struct packed {
    logic [9:0]  minutes;
    logic [5:0]  seconds;
    logic [7:0]  level;
    logic [15:0] tag;
  } rec_t;

  // what one cell hands to the next: its record and whether it loses to the candidate
  typedef struct packed {
    logic lt;
    rec_t rec;
  } cell_link_t;

  function automatic logic [KEY_W-1:0] time_key(rec_t r);
    return {r.minutes, r.seconds};
  endfunction

endpackage

[rtl/core/tkl_cell.sv]
`timescale 1ns / 1ps
module tkl_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  tkl_pkg::cell_link_t link_in,
  input  tkl_pkg::rec_t     cand,
  input  logic              shift_en,
  output tkl_pkg::cell_link_t link_out
);
  import tkl_pkg::*;

  rec_t rec_r;
  rec_t rec_nxt;
  logic key_lt;

  assign key_lt = time_key(rec_r) < time_key(cand);

  // losing cells either take the candidate (first loser) or the upper neighbour's record
  always_comb begin
    rec_nxt = rec_r;
    if (shift_en && key_lt) begin
      rec_nxt = link_in.lt ? link_in.rec : cand;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rec_r <= '0;
    end else begin
      rec_r <= rec_nxt;
    end
  end

  assign link_out.lt  = key_lt;
  assign link_out.rec = rec_r;

endmodule

[rtl/core/top_k_time_leaderboard.sv]
`timescale 1ns / 1ps
// Top-k leaderboard of (minutes, seconds) times, best first, held in a row of
// cells, one record per cell. Every cell compares its record with the
// candidate at once and the losers shift down one place in the same cycle, so
// a transaction is taken every cycle unless the output stalls, and its result
// appears in the output register in the cycle after acceptance. A read
// returns one slot through a multiplexer over the cells. The table clears to
// zero on reset with no clearing pass.
module top_k_time_leaderboard (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_command,
  input  logic [9:0]  in_cand_minutes,
  input  logic [5:0]  in_cand_seconds,
  input  logic [7:0]  in_cand_level,
  input  logic [15:0] in_player_tag,
  input  logic [3:0]  in_slot_index,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_entered,
  output logic [3:0]  out_placed_at,
  output logic [9:0]  out_minutes,
  output logic [5:0]  out_seconds,
  output logic [7:0]  out_level,
  output logic [15:0] out_tag
);
  import tkl_pkg::*;

  cell_link_t chain [ENTRIES+1];
  rec_t       cand;
  logic       in_acc;
  logic       enter;
  logic [PLACE_W-1:0] pos;
  rec_t       rd_rec;
  logic       sorted;

  logic               out_valid_r, out_valid_nxt;
  logic               entered_r, entered_nxt;
  logic [PLACE_W-1:0] placed_r, placed_nxt;
  rec_t               rd_r, rd_nxt;

  assign in_stall = out_valid_r && out_stall;
  assign in_acc   = in_valid && !in_stall;

  assign cand.minutes = in_cand_minutes;
  assign cand.seconds = in_cand_seconds;
  assign cand.level   = in_cand_level;
  assign cand.tag     = in_player_tag;

  assign chain[0] = '0;
  assign enter    = in_acc && (in_command == CMD_INSERT) && chain[ENTRIES].lt;

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    tkl_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .link_in  (chain[g]),
      .cand     (cand),
      .shift_en (enter),
      .link_out (chain[g+1])
    );
  end

  // landing slot is the first cell whose record loses to the candidate
  always_comb begin
    pos = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (chain[i+1].lt && !chain[i].lt) begin
        pos = pos | PLACE_W'(i);
      end
    end
  end

  always_comb begin
    rd_rec = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (32'(in_slot_index) == i) begin
        rd_rec = chain[i+1].rec;
      end
    end
  end

  always_comb begin
    out_valid_nxt = in_acc || (out_valid_r && out_stall);
    entered_nxt   = entered_r;
    placed_nxt    = placed_r;
    rd_nxt        = rd_r;
    if (in_acc) begin
      entered_nxt = enter;
      placed_nxt  = enter ? pos : '0;
      rd_nxt      = (in_command == CMD_READ) ? rd_rec : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    entered_r <= entered_nxt;
    placed_r  <= placed_nxt;
    rd_r      <= rd_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_entered   = entered_r;
  assign out_placed_at = placed_r;
  assign out_minutes   = rd_r.minutes;
  assign out_seconds   = rd_r.seconds;
  assign out_level     = rd_r.level;
  assign out_tag       = rd_r.tag;

  always_comb begin
    sorted = 1'b1;
    for (int i = 1; i < ENTRIES; i++) begin
      if (time_key(chain[i+1].rec) > time_key(chain[i].rec)) begin
        sorted = 1'b0;
      end
    end
  end

`ifndef SYNTH
  a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> out_valid)
    else $error("accepted transaction produced no result");

  a_table_sorted: assert property (@(posedge clk) disable iff (!rst_n)
    sorted)
    else $error("leaderboard lost its descending order");

  a_placed_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_entered) |-> (32'(out_placed_at) < ENTRIES))
    else $error("landing slot beyond table");

  a_entered_is_insert: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_command == CMD_READ) |=> !out_entered)
    else $error("read reported an entry");
`endif

endmodule
